@@ hw/rtl/gaussian_filament_concentration_macros.svh @@
// assertion macros for the filament concentration block
// used by the port checker, no other dependencies
`ifndef GAUSSIAN_FILAMENT_CONCENTRATION_MACROS_SVH
`define GAUSSIAN_FILAMENT_CONCENTRATION_MACROS_SVH

// same-cycle implication, disabled during reset
`define FGC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fgc assertion failed");

// next-cycle implication, disabled during reset
`define FGC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fgc assertion failed");

`endif

@@ hw/rtl/fgc_pkg.sv @@
// shared constants, types and tables for the filament concentration block
// no dependencies
package fgc_pkg;

   localparam int MAX_FIL   = 256;
   localparam int IDX_W     = $clog2(MAX_FIL);
   localparam int KIND_W    = 4;
   localparam int SLOT_W    = 8;
   localparam int DIV_NUM_W = 128;
   localparam int DIV_DEN_W = 64;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [31:0] CUT_RESET  = 32'd65536;
   localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
   localparam logic [32:0] LOG2E_Q    = 33'd6196328019;
   localparam logic [32:0] LN2_Q      = 33'd2977044472;
   localparam logic [32:0] INV_NORM_Q = 33'd272703090;
   localparam logic [32:0] RECIP3     = 33'h0_AAAA_AAAB;
   localparam logic [63:0] T_LIMIT    = 64'd1507328;

   typedef struct packed {
      logic [31:0]       x;
      logic [31:0]       y;
      logic [31:0]       z;
      logic [31:0]       width;
      logic [31:0]       amount;
      logic [KIND_W-1:0] kind;
   } fil_entry_type;

   // 2^(-j/8) in q1.32
   function automatic logic [32:0] pow2_tab(input logic [2:0] j);
      logic [32:0] v;
      case (j)
         3'd0: v = 33'd4294967296;
         3'd1: v = 33'd3938502376;
         3'd2: v = 33'd3611622603;
         3'd3: v = 33'd3311872529;
         3'd4: v = 33'd3037000500;
         3'd5: v = 33'd2784941738;
         3'd6: v = 33'd2553802834;
         default: v = 33'd2341847524;
      endcase
      return v;
   endfunction

endpackage

@@ hw/rtl/fgc_div.sv @@
// restoring divider, one quotient bit per cycle, wide dividend
// depends on fgc_pkg
module fgc_div import fgc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 div_start,
   input  logic [DIV_NUM_W-1:0] div_num,
   input  logic [DIV_DEN_W-1:0] div_den,
   output logic                 div_done,
   output logic [DIV_NUM_W-1:0] div_quo
);

   logic                 run_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_NUM_W-1:0] n_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;

   logic [DIV_DEN_W-1:0] rem_sh;
   logic                 take;
   logic [DIV_DEN_W-1:0] rem_in;
   logic [DIV_NUM_W-1:0] n_in;

   always_comb begin
      rem_sh = {rem_ff[DIV_DEN_W-2:0], n_ff[DIV_NUM_W-1]};
      // a bit shifted out of the remainder means it already exceeds den
      take   = rem_ff[DIV_DEN_W-1] || (rem_sh >= den_ff);
      rem_in = take ? (rem_sh - den_ff) : rem_sh;
      n_in   = {n_ff[DIV_NUM_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         n_ff   <= div_num;
         rem_ff <= '0;
         den_ff <= div_den;
      end else if (run_ff) begin
         n_ff   <= n_in;
         rem_ff <= rem_in;
      end
   end

   assign div_done = done_ff;
   assign div_quo  = n_ff;

endmodule

@@ hw/rtl/gaussian_filament_concentration.sv @@
// odor filament concentration block: filament table and query sequencer
// depends on fgc_pkg and fgc_div
//
// Usage:
//   A beat on the request side is taken when start is high and busy is low.
//   req_operation selects a slot write or a concentration query.
//   A write fills one table slot in the cycle it is taken; busy stays low and
//   no response follows.
//   A query raises busy and walks all 256 slots through one shared 33x33
//   multiplier and one bit-serial 128-bit divider. A slot that does not match
//   costs only the read, check and next steps; a matching slot inside the cut
//   radius takes up to four divider passes plus the squares, compare and exp
//   steps.
//   The response beat shows on rsp_valid for one cycle as busy falls; the
//   receiver cannot stall it.
//   csr_write_enable writes the cut radius; write it only while idle.
//   Synchronous reset clears all slot valid bits, sets the cut radius to 1.0
//   and returns to idle. Slot contents are undefined until written.
module gaussian_filament_concentration import fgc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [KIND_W-1:0]  req_odor_kind,
   input  logic [31:0]        req_amount,
   input  logic [31:0]        req_spread,
   input  logic               req_present,
   output logic               rsp_valid,
   output logic [63:0]        rsp_concentration,
   output logic               rsp_saturated,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_R2, S_RD, S_CHK, S_NEXT, S_SQX, S_SQY, S_SQZ, S_CMP, S_D1W,
      S_EXP0, S_EXP1, S_E2M, S_E2D, S_E3, S_E4, S_E5, S_E6, S_E7,
      S_D2W, S_D3W, S_D4W, S_F0, S_F1, S_F2, S_F3
   } state_type;

   state_type     state_ff;
   logic [31:0]   cut_ff;
   logic [IDX_W-1:0] idx_ff;
   logic          valid_ff [MAX_FIL];
   fil_entry_type mem_ff [MAX_FIL];
   fil_entry_type rd_ff;

   logic [31:0]       qx_ff, qy_ff, qz_ff;
   logic [KIND_W-1:0] qkind_ff;
   logic [63:0]   r2_ff;
   logic [31:0]   ax_ff, ay_ff, az_ff;
   logic [63:0]   d2_ff;
   logic          ovf_ff;
   logic [20:0]   t_ff;
   logic [21:0]   u_ff;
   logic [28:0]   x_ff;
   logic [32:0]   a_ff;
   logic [29:0]   m_ff;
   logic [32:0]   e_ff;
   logic [127:0]  acc_ff;
   logic [63:0]   hk_ff;
   logic [31:0]   lt_ff;
   logic [63:0]   mid_ff;
   logic          sat_ff;

   logic                 div_start_ff;
   logic [DIV_NUM_W-1:0] div_num_ff;
   logic [DIV_DEN_W-1:0] div_den_ff;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quo;

   logic          rsp_valid_ff;
   logic [63:0]   rsp_conc_ff;
   logic          rsp_sat_ff;

   logic          wr_en;
   fil_entry_type wr_entry;
   logic [32:0]   mul_a, mul_b;
   logic [65:0]   mul_p;
   logic [32:0]   dx, dy, dz, nx, ny, nz;
   logic [64:0]   d2_sum;
   logic [64:0]   res_sum;

   fgc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_start(div_start_ff),
      .div_num  (div_num_ff),
      .div_den  (div_den_ff),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   assign busy = (state_ff != S_IDLE);
   assign wr_en = start && !busy && (req_operation == OP_WRITE)
                  && ({1'b0, req_slot} < (SLOT_W + 1)'(MAX_FIL));

   always_comb begin
      wr_entry.x      = req_pos_x;
      wr_entry.y      = req_pos_y;
      wr_entry.z      = req_pos_z;
      wr_entry.width  = req_spread;
      wr_entry.amount = req_amount;
      wr_entry.kind   = req_odor_kind;
   end

   // filament table, registered read at the walk index
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[req_slot[IDX_W-1:0]] <= wr_entry;
      end
      rd_ff <= mem_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_FIL; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         valid_ff[req_slot[IDX_W-1:0]] <= req_present;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cut_ff <= CUT_RESET;
      end else if (csr_write_enable) begin
         cut_ff <= csr_write_data;
      end
   end

   // signed coordinate differences and their negations, 33-bit exact
   always_comb begin
      dx = {qx_ff[31], qx_ff} - {rd_ff.x[31], rd_ff.x};
      dy = {qy_ff[31], qy_ff} - {rd_ff.y[31], rd_ff.y};
      dz = {qz_ff[31], qz_ff} - {rd_ff.z[31], rd_ff.z};
      nx = 33'd0 - dx;
      ny = 33'd0 - dy;
      nz = 33'd0 - dz;
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_R2:   begin mul_a = {1'b0, cut_ff};      mul_b = {1'b0, cut_ff}; end
         S_SQX:  begin mul_a = {1'b0, ax_ff};       mul_b = {1'b0, ax_ff}; end
         S_SQY:  begin mul_a = {1'b0, ay_ff};       mul_b = {1'b0, ay_ff}; end
         S_SQZ:  begin mul_a = {1'b0, az_ff};       mul_b = {1'b0, az_ff}; end
         S_CMP:  begin mul_a = {1'b0, rd_ff.width}; mul_b = {1'b0, rd_ff.width}; end
         S_EXP0: begin mul_a = {12'b0, t_ff};       mul_b = LOG2E_Q; end
         S_EXP1: begin mul_a = {20'b0, u_ff[12:0]}; mul_b = LN2_Q; end
         S_E2M, S_E3, S_E4: begin
            mul_a = {4'b0, x_ff};
            mul_b = a_ff;
         end
         S_E2D:  begin mul_a = {3'b0, m_ff};        mul_b = RECIP3; end
         S_E5:   begin mul_a = pow2_tab(u_ff[15:13]); mul_b = {1'b0, a_ff[32:1]}; end
         S_E7:   begin mul_a = {1'b0, rd_ff.amount}; mul_b = e_ff; end
         S_F0:   begin mul_a = {1'b0, acc_ff[95:64]}; mul_b = INV_NORM_Q; end
         S_F1:   begin mul_a = {1'b0, acc_ff[31:0]};  mul_b = INV_NORM_Q; end
         S_F2:   begin mul_a = {1'b0, acc_ff[63:32]}; mul_b = INV_NORM_Q; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign mul_p   = {33'b0, mul_a} * {33'b0, mul_b};
   assign d2_sum  = {1'b0, d2_ff} + {1'b0, mul_p[63:0]};
   assign res_sum = {1'b0, hk_ff[31:0], 32'b0} + {1'b0, mid_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start && req_operation == OP_QUERY) begin
                  qx_ff    <= req_pos_x;
                  qy_ff    <= req_pos_y;
                  qz_ff    <= req_pos_z;
                  qkind_ff <= req_odor_kind;
                  state_ff <= S_R2;
               end
            end
            S_R2: begin
               r2_ff    <= mul_p[63:0];
               idx_ff   <= '0;
               acc_ff   <= '0;
               state_ff <= S_RD;
            end
            S_RD: state_ff <= S_CHK;
            S_CHK: begin
               if (!valid_ff[idx_ff] || rd_ff.kind != qkind_ff || rd_ff.width == 32'd0) begin
                  state_ff <= S_NEXT;
               end else begin
                  ax_ff    <= dx[32] ? nx[31:0] : dx[31:0];
                  ay_ff    <= dy[32] ? ny[31:0] : dy[31:0];
                  az_ff    <= dz[32] ? nz[31:0] : dz[31:0];
                  state_ff <= S_SQX;
               end
            end
            S_NEXT: begin
               if (idx_ff == IDX_W'(MAX_FIL - 1)) begin
                  state_ff <= S_F0;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_SQX: begin
               d2_ff    <= mul_p[63:0];
               ovf_ff   <= 1'b0;
               state_ff <= S_SQY;
            end
            S_SQY: begin
               d2_ff    <= d2_sum[63:0];
               ovf_ff   <= d2_sum[64];
               state_ff <= S_SQZ;
            end
            S_SQZ: begin
               d2_ff    <= d2_sum[63:0];
               ovf_ff   <= ovf_ff | d2_sum[64];
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (ovf_ff || d2_ff > r2_ff) begin
                  state_ff <= S_NEXT;
               end else begin
                  div_num_ff   <= {48'b0, d2_ff, 16'b0};
                  div_den_ff   <= mul_p[63:0];
                  div_start_ff <= 1'b1;
                  state_ff     <= S_D1W;
               end
            end
            S_D1W: begin
               if (div_done) begin
                  if (div_quo[127:64] != 64'd0 || div_quo[63:0] >= T_LIMIT) begin
                     state_ff <= S_NEXT;
                  end else begin
                     t_ff     <= div_quo[20:0];
                     state_ff <= S_EXP0;
                  end
               end
            end
            S_EXP0: begin
               u_ff     <= mul_p[53:32];
               state_ff <= S_EXP1;
            end
            S_EXP1: begin
               // integer part of 32 or more underflows to zero
               if (u_ff[21]) begin
                  state_ff <= S_NEXT;
               end else begin
                  x_ff     <= mul_p[44:16];
                  a_ff     <= ONE_Q32 - {6'b0, mul_p[44:18]};
                  state_ff <= S_E2M;
               end
            end
            S_E2M: begin
               m_ff     <= mul_p[61:32];
               state_ff <= S_E2D;
            end
            S_E2D: begin
               // divide by 3 via reciprocal, exact below 2^32
               a_ff     <= ONE_Q32 - {4'b0, mul_p[61:33]};
               state_ff <= S_E3;
            end
            S_E3: begin
               a_ff     <= ONE_Q32 - {4'b0, mul_p[61:33]};
               state_ff <= S_E4;
            end
            S_E4: begin
               a_ff     <= ONE_Q32 - {3'b0, mul_p[61:32]};
               state_ff <= S_E5;
            end
            S_E5: begin
               e_ff     <= mul_p[63:31];
               state_ff <= S_E6;
            end
            S_E6: begin
               e_ff     <= e_ff >> u_ff[20:16];
               state_ff <= S_E7;
            end
            S_E7: begin
               div_num_ff   <= {32'b0, mul_p[63:0], 32'b0};
               div_den_ff   <= {32'b0, rd_ff.width};
               div_start_ff <= 1'b1;
               state_ff     <= S_D2W;
            end
            S_D2W: begin
               if (div_done) begin
                  div_num_ff   <= div_quo;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_D3W;
               end
            end
            S_D3W: begin
               if (div_done) begin
                  div_num_ff   <= div_quo;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_D4W;
               end
            end
            S_D4W: begin
               if (div_done) begin
                  acc_ff   <= acc_ff + div_quo;
                  state_ff <= S_NEXT;
               end
            end
            S_F0: begin
               hk_ff    <= mul_p[63:0];
               sat_ff   <= (acc_ff[127:96] != 32'd0);
               state_ff <= S_F1;
            end
            S_F1: begin
               lt_ff    <= mul_p[63:32];
               sat_ff   <= sat_ff | (hk_ff[63:32] != 32'd0);
               state_ff <= S_F2;
            end
            S_F2: begin
               mid_ff   <= mul_p[63:0] + {32'b0, lt_ff};
               state_ff <= S_F3;
            end
            S_F3: begin
               rsp_valid_ff <= 1'b1;
               rsp_sat_ff   <= sat_ff | res_sum[64];
               rsp_conc_ff  <= (sat_ff | res_sum[64]) ? '1 : res_sum[63:0];
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_concentration = rsp_conc_ff;
   assign rsp_saturated     = rsp_sat_ff;

endmodule

@@ hw/rtl/fgc_checker.sv @@
// port-level checker for the filament concentration block, bound to the top
// depends on fgc_pkg and the macros header
`include "gaussian_filament_concentration_macros.svh"

module fgc_checker import fgc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_operation,
   input logic               rsp_valid,
   input logic [63:0]        rsp_concentration,
   input logic               rsp_saturated
);

   // a query beat occupies the block
   `FGC_ASSERT_NEXT(a_query_busy, clock, reset, start && !busy && req_operation == OP_QUERY, busy)
   // a write beat completes at once
   `FGC_ASSERT_NEXT(a_write_free, clock, reset, start && !busy && req_operation == OP_WRITE, !busy)
   // response ends the busy period
   `FGC_ASSERT_NOW(a_rsp_end, clock, reset, rsp_valid, !busy && $past(busy))
   // a clamped result reads all ones
   `FGC_ASSERT_NOW(a_sat_max, clock, reset, rsp_valid && rsp_saturated, rsp_concentration == 64'hFFFF_FFFF_FFFF_FFFF)

endmodule

bind gaussian_filament_concentration fgc_checker u_fgc_checker (.*);
